// ===== hdl/i2cb_pkg.sv =====
// Package for the I2C register burst master: item types, phase and byte codes,
// state record and its reset value. No dependencies.

package i2cb_pkg;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_BYTE  = 2'd3;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_START = 3'd1;
	localparam logic [2:0] PH_SEND  = 3'd2;
	localparam logic [2:0] PH_SACK  = 3'd3;
	localparam logic [2:0] PH_RECV  = 3'd4;
	localparam logic [2:0] PH_MACK  = 3'd5;
	localparam logic [2:0] PH_STOP  = 3'd6;
	localparam logic [2:0] PH_WAIT  = 3'd7;

	localparam logic [1:0] IT_ADDRW = 2'd0;
	localparam logic [1:0] IT_REG   = 2'd1;
	localparam logic [1:0] IT_ADDRR = 2'd2;
	localparam logic [1:0] IT_DATA  = 2'd3;

	localparam logic ACK_LVL  = 1'b0;
	localparam logic NACK_LVL = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [6:0] device_addr;
		logic [7:0] reg_addr;
		logic [7:0] byte_count;
		logic [7:0] tx_byte;
		logic       sda_sample;
	} cmd_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       need_byte;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       done_res;
		logic       status;
	} res_item_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [1:0] step;
		logic [2:0] bit_idx;
		logic [7:0] shift_reg;
		logic [7:0] bytes_left;
		logic       is_read;
		logic [6:0] target_addr;
		logic [7:0] register_addr;
		logic       scl_drive;
		logic       sda_drive;
		logic [1:0] cur_item;
		logic       abort_flag;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase: PH_IDLE, step: 2'd0, bit_idx: 3'd0, shift_reg: 8'd0,
		bytes_left: 8'd0, is_read: 1'b0, target_addr: 7'd0,
		register_addr: 8'd0, scl_drive: 1'b1, sda_drive: 1'b1,
		cur_item: IT_ADDRW, abort_flag: 1'b0
	};

endpackage

// ===== hdl/i2cb_chan_if.sv =====
// Valid/ready channel interfaces for command and result transactions.
// Depends on i2cb_pkg for the payload types.

interface i2cb_cmd_if;
	logic                  valid;
	logic                  ready;
	i2cb_pkg::cmd_item_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface i2cb_res_if;
	logic                  valid;
	logic                  ready;
	i2cb_pkg::res_item_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/i2cb_step.sv =====
// Next-state and result logic for one command transaction of the I2C master.
// Depends on i2cb_pkg.

module i2cb_step (
	input  i2cb_pkg::state_t    st,
	input  i2cb_pkg::cmd_item_t cmd,
	output i2cb_pkg::state_t    nx,
	output i2cb_pkg::res_item_t res
);

	function automatic i2cb_pkg::state_t go_to(i2cb_pkg::state_t s, logic [2:0] ph);
		i2cb_pkg::state_t r;
		r = s;
		r.phase = ph;
		r.step = 2'd0;
		r.bit_idx = 3'd0;
		return r;
	endfunction

	logic       rx_v;
	logic [7:0] rx_b;
	logic       done;
	logic       stat;

	always_comb begin
		nx = st;
		rx_v = 1'b0;
		rx_b = 8'd0;
		done = 1'b0;
		stat = 1'b0;
		case (cmd.req_type)
			i2cb_pkg::REQ_READ, i2cb_pkg::REQ_WRITE: begin
				if (st.phase == i2cb_pkg::PH_IDLE) begin
					nx.target_addr = cmd.device_addr;
					nx.register_addr = cmd.reg_addr;
					nx.bytes_left = cmd.byte_count;
					nx.is_read = (cmd.req_type == i2cb_pkg::REQ_READ);
					nx.abort_flag = 1'b0;
					nx.cur_item = i2cb_pkg::IT_ADDRW;
					nx = go_to(nx, i2cb_pkg::PH_START);
				end
			end
			i2cb_pkg::REQ_BYTE: begin
				if (st.phase == i2cb_pkg::PH_WAIT) begin
					nx.shift_reg = cmd.tx_byte;
					nx.cur_item = i2cb_pkg::IT_DATA;
					nx = go_to(nx, i2cb_pkg::PH_SEND);
				end
			end
			default: begin
				case (st.phase)
					i2cb_pkg::PH_START: begin
						case (st.step)
							2'd0: nx.sda_drive = 1'b1;
							2'd1: nx.scl_drive = 1'b1;
							2'd2: nx.sda_drive = 1'b0;
							default: nx.scl_drive = 1'b0;
						endcase
						if (st.step != 2'd3) begin
							nx.step = st.step + 2'd1;
						end else begin
							nx.shift_reg = {st.target_addr,
								st.cur_item == i2cb_pkg::IT_ADDRR};
							nx = go_to(nx, i2cb_pkg::PH_SEND);
						end
					end
					i2cb_pkg::PH_SEND: begin
						case (st.step)
							2'd0: begin
								nx.sda_drive = st.shift_reg[7];
								nx.step = 2'd1;
							end
							2'd1: begin
								nx.scl_drive = 1'b1;
								nx.step = 2'd2;
							end
							default: begin
								nx.scl_drive = 1'b0;
								nx.shift_reg = {st.shift_reg[6:0], 1'b0};
								nx.bit_idx = st.bit_idx + 3'd1;
								nx.step = 2'd0;
								if (st.bit_idx == 3'd7) nx = go_to(nx, i2cb_pkg::PH_SACK);
							end
						endcase
					end
					i2cb_pkg::PH_SACK: begin
						case (st.step)
							2'd0: begin
								nx.sda_drive = 1'b1;
								nx.step = 2'd1;
							end
							2'd1: begin
								nx.scl_drive = 1'b1;
								nx.step = 2'd2;
							end
							default: begin
								nx.scl_drive = 1'b0;
								case (st.cur_item)
									i2cb_pkg::IT_ADDRW: begin
										if (cmd.sda_sample != i2cb_pkg::ACK_LVL) begin
											nx.abort_flag = 1'b1;
											nx = go_to(nx, i2cb_pkg::PH_STOP);
										end else begin
											nx.shift_reg = st.register_addr;
											nx.cur_item = i2cb_pkg::IT_REG;
											nx = go_to(nx, i2cb_pkg::PH_SEND);
										end
									end
									i2cb_pkg::IT_REG: begin
										if (st.is_read) begin
											nx.cur_item = i2cb_pkg::IT_ADDRR;
											nx = go_to(nx, i2cb_pkg::PH_START);
										end else if (st.bytes_left == 8'd0) begin
											nx = go_to(nx, i2cb_pkg::PH_STOP);
										end else begin
											nx = go_to(nx, i2cb_pkg::PH_WAIT);
										end
									end
									i2cb_pkg::IT_ADDRR: begin
										// acknowledge after address+R is not checked
										if (st.bytes_left == 8'd0) begin
											nx = go_to(nx, i2cb_pkg::PH_STOP);
										end else begin
											nx.shift_reg = 8'd0;
											nx = go_to(nx, i2cb_pkg::PH_RECV);
										end
									end
									default: begin
										if (cmd.sda_sample != i2cb_pkg::ACK_LVL) begin
											nx.abort_flag = 1'b1;
											nx = go_to(nx, i2cb_pkg::PH_STOP);
										end else begin
											nx.bytes_left = st.bytes_left - 8'd1;
											if (st.bytes_left == 8'd1)
												nx = go_to(nx, i2cb_pkg::PH_STOP);
											else
												nx = go_to(nx, i2cb_pkg::PH_WAIT);
										end
									end
								endcase
							end
						endcase
					end
					i2cb_pkg::PH_RECV: begin
						case (st.step)
							2'd0: begin
								nx.sda_drive = 1'b1;
								nx.step = 2'd1;
							end
							2'd1: begin
								nx.scl_drive = 1'b1;
								nx.step = 2'd2;
							end
							default: begin
								nx.shift_reg = {st.shift_reg[6:0], cmd.sda_sample};
								nx.scl_drive = 1'b0;
								nx.bit_idx = st.bit_idx + 3'd1;
								nx.step = 2'd0;
								if (st.bit_idx == 3'd7) nx = go_to(nx, i2cb_pkg::PH_MACK);
							end
						endcase
					end
					i2cb_pkg::PH_MACK: begin
						case (st.step)
							2'd0: begin
								nx.sda_drive = (st.bytes_left == 8'd1) ?
									i2cb_pkg::NACK_LVL : i2cb_pkg::ACK_LVL;
								nx.step = 2'd1;
							end
							2'd1: begin
								nx.scl_drive = 1'b1;
								nx.step = 2'd2;
							end
							default: begin
								nx.scl_drive = 1'b0;
								rx_v = 1'b1;
								rx_b = st.shift_reg;
								nx.bytes_left = st.bytes_left - 8'd1;
								if (st.bytes_left == 8'd1) begin
									nx = go_to(nx, i2cb_pkg::PH_STOP);
								end else begin
									nx.shift_reg = 8'd0;
									nx = go_to(nx, i2cb_pkg::PH_RECV);
								end
							end
						endcase
					end
					i2cb_pkg::PH_STOP: begin
						case (st.step)
							2'd0: begin
								nx.sda_drive = 1'b0;
								nx.step = 2'd1;
							end
							2'd1: begin
								nx.scl_drive = 1'b1;
								nx.step = 2'd2;
							end
							default: begin
								nx.sda_drive = 1'b1;
								done = 1'b1;
								stat = st.abort_flag;
								nx.abort_flag = 1'b0;
								nx = go_to(nx, i2cb_pkg::PH_IDLE);
							end
						endcase
					end
					default: ;
				endcase
			end
		endcase

		res.scl_level = nx.scl_drive;
		res.sda_level = nx.sda_drive;
		res.busy_res = (nx.phase != i2cb_pkg::PH_IDLE);
		res.need_byte = (nx.phase == i2cb_pkg::PH_WAIT);
		res.rx_valid = rx_v;
		res.rx_byte = rx_b;
		res.done_res = done;
		res.status = stat;
	end

endmodule

// ===== hdl/i2c_master_register_burst.sv =====
// I2C register burst master, top level: state and result registers around the step logic.
// Depends on i2cb_pkg, i2cb_chan_if and i2cb_step.
// The result transaction of an accepted command transaction is registered and offered in the cycle after acceptance.
// Throughput: one command transaction per cycle while results are taken; the state register closes the only loop.
// Reset: arst_n clears the bus state (both lines released, idle) and empties the result register.

module i2c_master_register_burst (
	input  logic clk,
	input  logic arst_n,
	i2cb_cmd_if.sink   cmd,
	i2cb_res_if.source res
);

	i2cb_pkg::state_t    state_q;
	i2cb_pkg::state_t    state_nx;
	i2cb_pkg::res_item_t res_nx;
	i2cb_pkg::res_item_t res_data_q;
	logic                res_valid_q;
	logic                cmd_fire;

	// Take a new command whenever the result register is empty or drains this cycle.
	assign cmd.ready = !res_valid_q || res.ready;
	assign cmd_fire  = cmd.valid && cmd.ready;

	i2cb_step u_step (
		.st  (state_q),
		.cmd (cmd.data),
		.nx  (state_nx),
		.res (res_nx)
	);

	// Advance the bus state only on an accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cb_pkg::STATE_RESET;
		end else if (cmd_fire) begin
			state_q <= state_nx;
		end
	end

	// Hold the result until taken; load the next one in the same cycle it drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			res_data_q <= res_nx;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

endmodule

// ===== hdl/i2cb_checker.sv =====
// Port-level checks for the I2C register burst master, with the bind that attaches them.
// Depends on i2cb_pkg and i2c_master_register_burst.

module i2cb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_ready,
	input logic                res_valid,
	input logic                res_ready,
	input i2cb_pkg::res_item_t res_data
);

	// Drop command acceptance while a result is stalled.
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |-> !cmd_ready)
		else $error("command accepted while result stalled");

	// Every accepted command yields a result on the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> res_valid)
		else $error("no result after accepted command");

	// Hold a stalled result.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
		else $error("stalled result changed");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.done_res) |-> (!res_data.busy_res && res_data.scl_level
			&& res_data.sda_level))
		else $error("done without idle released bus");

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.status) |-> res_data.done_res)
		else $error("error status outside done");

endmodule

bind i2c_master_register_burst i2cb_checker u_i2cb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
